// File: rtl/rle_pkg.sv
`default_nettype none

package rle_pkg;

  // Default size of the peer table
  localparam int MAX_PEERS_DEF = 8;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_ID    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_COUNT = 1'd1;

  // Input command codes
  localparam logic [1:0] CMD_TIMEOUT  = 2'd0;
  localparam logic [1:0] CMD_REQUEST  = 2'd1;
  localparam logic [1:0] CMD_REPLY    = 2'd2;
  localparam logic [1:0] CMD_LOG_TAIL = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_VOTE_REQ = 2'd0;
  localparam logic [1:0] KIND_ANSWER   = 2'd1;
  localparam logic [1:0] KIND_LEADER   = 2'd2;

  // Answer reasons
  localparam logic [1:0] VS_NORMAL  = 2'd0;
  localparam logic [1:0] VS_EXPIRED = 2'd1;
  localparam logic [1:0] VS_VOTED   = 2'd2;

  typedef enum logic [1:0] {
    OP_TIMEOUT,
    OP_REQUEST,
    OP_REPLY,
    OP_LOG_TAIL
  } op_t;

  typedef enum logic [1:0] {
    ROLE_FOLLOWER,
    ROLE_CANDIDATE,
    ROLE_LEADER
  } role_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REQ,
    BK_FILL
  } bk_state_t;

  // One classified transaction waiting for the back end
  typedef struct packed {
    op_t                op;
    logic [31:0]        term;
    logic [7:0]         sender;
    logic signed [31:0] lidx;
    logic [31:0]        lterm;
    logic [31:0]        rterm;
    logic               grant;
    logic               slot_ok;
  } rle_entry_t;

endpackage

`default_nettype wire

// File: rtl/rle_front.sv
`default_nettype none

module rle_front #(
  parameter int MAX_PEERS = rle_pkg::MAX_PEERS_DEF,
  localparam int PW = $clog2(MAX_PEERS + 1)
) (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               cmd,
  input  logic [31:0]              term,
  input  logic [7:0]               sender_id,
  input  logic signed [31:0]       entry_index,
  input  logic [31:0]              entry_term,
  input  logic [31:0]              request_term,
  input  logic                     granted,
  input  logic [PW-1:0]            np,
  output logic                     push_valid,
  input  logic                     push_ready,
  output rle_pkg::rle_entry_t      push_data
);
  import rle_pkg::*;

  op_t op;

  // Decode the command
  always_comb begin
    unique case (cmd)
      CMD_TIMEOUT: op = OP_TIMEOUT;
      CMD_REQUEST: op = OP_REQUEST;
      CMD_REPLY:   op = OP_REPLY;
      default:     op = OP_LOG_TAIL;
    endcase
  end

  // Build the queue entry; reply slot is checked against the active peer count
  always_comb begin
    push_data.op      = op;
    push_data.term    = term;
    push_data.sender  = sender_id;
    push_data.lidx    = entry_index;
    push_data.lterm   = entry_term;
    push_data.rterm   = request_term;
    push_data.grant   = granted;
    push_data.slot_ok = 16'(sender_id) < 16'(np);
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

`default_nettype wire

// File: rtl/rle_queue.sv
`default_nettype none

module rle_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  rle_pkg::rle_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output rle_pkg::rle_entry_t pop_data
);
  import rle_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  rle_entry_t     slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != QCW'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rle_back.sv
`default_nettype none

module rle_back #(
  parameter int MAX_PEERS = rle_pkg::MAX_PEERS_DEF,
  localparam int PW = $clog2(MAX_PEERS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          self_id,
  input  logic [PW-1:0]       np,
  input  logic                q_valid,
  output logic                q_pop,
  input  rle_pkg::rle_entry_t q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic [2:0]          peer_slot,
  output logic [31:0]         msg_term,
  output logic [7:0]          msg_candidate,
  output logic signed [31:0]  msg_last_index,
  output logic [31:0]         msg_last_term,
  output logic                answer_grant,
  output logic [1:0]          vote_state,
  output logic [30:0]         next_index_out,
  output logic                restart_timer,
  output logic                last
);
  import rle_pkg::*;

  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int TW = PW + 6;

  // Node state
  bk_state_t          st, st_next;
  role_t              role, role_next;
  logic [31:0]        cur_term, cur_term_next;
  logic               voted_valid, voted_valid_next;
  logic [7:0]         voted_id, voted_id_next;
  logic [3:0]         votes_count, votes_count_next;
  logic [31:0]        own_last_term, own_last_term_next;
  logic signed [31:0] own_last_index, own_last_index_next;
  logic [PW-1:0]      cnt, cnt_next;
  logic               fill_restart, fill_restart_next;
  logic [31:0]        peer_next_index [MAX_PEERS];
  logic [31:0]        peer_match_index [MAX_PEERS];
  logic               fill_we;

  // Result being issued this cycle
  logic               emit;
  logic               emit_ok;
  logic [1:0]         o_kind;
  logic [2:0]         o_slot;
  logic [31:0]        o_term;
  logic [7:0]         o_cand;
  logic signed [31:0] o_lidx;
  logic [31:0]        o_lterm;
  logic               o_vg;
  logic [1:0]         o_vs;
  logic [30:0]        o_nidx;
  logic               o_restart;
  logic               o_last;

  // Decision terms
  logic               t_lt;
  logic               t_gt;
  logic               fresh;
  logic               vote_taken;
  logic [3:0]         votes_inc;
  logic               majority;
  logic [30:0]        nidx;
  logic               req_last;

  assign emit_ok = !out_valid || out_ready;

  assign t_lt = q_data.term < cur_term;
  assign t_gt = q_data.term > cur_term;
  assign fresh = (q_data.lterm > own_last_term) ||
                 ((q_data.lterm == own_last_term) &&
                  ($signed(q_data.lidx) >= own_last_index));
  assign vote_taken = voted_valid && !t_gt && (voted_id != q_data.sender);
  assign votes_inc  = (votes_count == 4'hF) ? votes_count : votes_count + 4'd1;
  assign majority   = TW'({votes_inc, 1'b0}) > (TW'(np) + TW'(1));
  assign req_last   = PW'(cnt + PW'(1)) == np;

  // Next index handed to peers: own last index plus one, clamped
  always_comb begin
    if (own_last_index[31]) begin
      nidx = '0;
    end else if (&own_last_index[30:0]) begin
      nidx = '1;
    end else begin
      nidx = own_last_index[30:0] + 31'd1;
    end
  end

  // Sequencer: next state, state updates and result selection
  always_comb begin
    st_next             = st;
    role_next           = role;
    cur_term_next       = cur_term;
    voted_valid_next    = voted_valid;
    voted_id_next       = voted_id;
    votes_count_next    = votes_count;
    own_last_term_next  = own_last_term;
    own_last_index_next = own_last_index;
    cnt_next            = cnt;
    fill_restart_next   = fill_restart;
    fill_we             = 1'b0;
    q_pop               = 1'b0;
    emit                = 1'b0;
    o_kind              = KIND_ANSWER;
    o_slot              = '0;
    o_term              = cur_term;
    o_cand              = '0;
    o_lidx              = '0;
    o_lterm             = '0;
    o_vg                = 1'b0;
    o_vs                = VS_NORMAL;
    o_nidx              = '0;
    o_restart           = 1'b0;
    o_last              = 1'b1;

    unique case (st)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_data.op)
            OP_TIMEOUT: begin
              q_pop = 1'b1;
              if (role != ROLE_LEADER) begin
                role_next        = ROLE_CANDIDATE;
                cur_term_next    = cur_term + 32'd1;
                voted_valid_next = 1'b1;
                voted_id_next    = self_id;
                votes_count_next = 4'd1;
                cnt_next         = '0;
                if (np == '0) begin
                  // single node wins at once
                  role_next         = ROLE_LEADER;
                  votes_count_next  = '0;
                  fill_restart_next = 1'b1;
                  st_next           = BK_FILL;
                end else begin
                  st_next = BK_REQ;
                end
              end
            end
            OP_REQUEST: begin
              if (emit_ok) begin
                q_pop = 1'b1;
                emit  = 1'b1;
                if (t_lt) begin
                  o_vs = VS_EXPIRED;
                end else begin
                  o_term        = q_data.term;
                  cur_term_next = q_data.term;
                  if (t_gt) begin
                    voted_valid_next = 1'b0;
                    voted_id_next    = '0;
                    role_next        = ROLE_FOLLOWER;
                  end
                  if (!fresh) begin
                    o_vs = VS_NORMAL;
                  end else if (vote_taken) begin
                    o_vs = VS_VOTED;
                  end else begin
                    role_next        = ROLE_FOLLOWER;
                    voted_valid_next = 1'b1;
                    voted_id_next    = q_data.sender;
                    o_vg             = 1'b1;
                    o_restart        = 1'b1;
                  end
                end
              end
            end
            OP_REPLY: begin
              q_pop = 1'b1;
              if (q_data.slot_ok && (q_data.rterm == cur_term) &&
                  (role == ROLE_CANDIDATE) && !t_lt) begin
                if (t_gt) begin
                  // higher term: step down
                  role_next        = ROLE_FOLLOWER;
                  voted_valid_next = 1'b0;
                  voted_id_next    = '0;
                  cur_term_next    = q_data.term;
                end else if (q_data.grant) begin
                  if (majority) begin
                    role_next         = ROLE_LEADER;
                    votes_count_next  = '0;
                    cnt_next          = '0;
                    fill_restart_next = 1'b0;
                    st_next           = BK_FILL;
                  end else begin
                    votes_count_next = votes_inc;
                  end
                end
              end
            end
            default: begin
              q_pop               = 1'b1;
              own_last_term_next  = q_data.lterm;
              own_last_index_next = $signed(q_data.lidx);
            end
          endcase
        end
      end
      BK_REQ: begin
        // one vote request per peer slot
        if (emit_ok) begin
          emit      = 1'b1;
          o_kind    = KIND_VOTE_REQ;
          o_slot    = 3'(cnt);
          o_cand    = self_id;
          o_lidx    = own_last_index;
          o_lterm   = own_last_term;
          o_restart = 1'b1;
          o_last    = req_last;
          cnt_next  = PW'(cnt + PW'(1));
          if (req_last) begin
            st_next = BK_IDLE;
          end
        end
      end
      BK_FILL: begin
        // sweep peer slots, then report leadership
        if (cnt < np) begin
          fill_we  = 1'b1;
          cnt_next = PW'(cnt + PW'(1));
        end else if (emit_ok) begin
          emit      = 1'b1;
          o_kind    = KIND_LEADER;
          o_nidx    = nidx;
          o_restart = fill_restart;
          st_next   = BK_IDLE;
        end
      end
      default: begin
        st_next = BK_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= BK_IDLE;
      role           <= ROLE_FOLLOWER;
      cur_term       <= '0;
      voted_valid    <= 1'b0;
      voted_id       <= '0;
      votes_count    <= '0;
      own_last_term  <= '0;
      own_last_index <= -32'sd1;
      cnt            <= '0;
      fill_restart   <= 1'b0;
    end else begin
      st             <= st_next;
      role           <= role_next;
      cur_term       <= cur_term_next;
      voted_valid    <= voted_valid_next;
      voted_id       <= voted_id_next;
      votes_count    <= votes_count_next;
      own_last_term  <= own_last_term_next;
      own_last_index <= own_last_index_next;
      cnt            <= cnt_next;
      fill_restart   <= fill_restart_next;
    end
  end

  // Per-peer replication indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PEERS; i++) begin
        peer_next_index[i]  <= '0;
        peer_match_index[i] <= '0;
      end
    end else if (fill_we) begin
      peer_next_index[cnt[IW-1:0]]  <= {1'b0, nidx};
      peer_match_index[cnt[IW-1:0]] <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind           <= o_kind;
      peer_slot      <= o_slot;
      msg_term       <= o_term;
      msg_candidate  <= o_cand;
      msg_last_index <= o_lidx;
      msg_last_term  <= o_lterm;
      answer_grant   <= o_vg;
      vote_state     <= o_vs;
      next_index_out <= o_nidx;
      restart_timer  <= o_restart;
      last           <= o_last;
    end
  end

`ifndef NO_ASSERTIONS
  // a result is never issued over one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> emit_ok)
    else $error("result issued while output register is held");

  // vote requests go out only as candidate, and only to live slots
  a_req_role: assert property (@(posedge clk) disable iff (rst)
    (st == BK_REQ) |-> (role == ROLE_CANDIDATE) && (cnt < np))
    else $error("vote request outside a candidacy or past peer count");

  // the fill sweep runs only for a leader
  a_fill_role: assert property (@(posedge clk) disable iff (rst)
    (st == BK_FILL) |-> (role == ROLE_LEADER) && (cnt <= np))
    else $error("peer fill without leadership");

  // when the sweep ends, slot zero holds the handed-out index
  a_fill_value: assert property (@(posedge clk) disable iff (rst)
    ((st == BK_FILL) && (cnt == np) && (np != '0)) |->
      (peer_next_index[0] == {1'b0, nidx}) && (peer_match_index[0] == '0))
    else $error("peer index table not filled");
`endif

endmodule

`default_nettype wire

// File: rtl/raft_leader_election_unit.sv
`default_nettype none

// Raft leader election core of one node. Commands arrive on the input channel
// (election timeout, vote request, vote reply, log tail update); a front end
// classifies each transaction and places it in a two-entry queue, and a back
// end sequencer executes it against the node state, issuing results through
// an output register. An election timeout with active peers is taken, and then
// one vote request is emitted per peer slot; with no peers the node becomes
// leader and issues the leader event. A reply that wins the election is taken,
// each peer slot is swept to load the next and match indexes, and then the
// leader event is issued. The back-end sequencer takes no other command until
// it is through with the last one, and handles one peer slot per cycle, unless
// the output side stalls a vote request.
// self_id and peer_count must be written through the configuration port only
// while the block is idle; the block itself does not enforce this. A
// peer_count above MAX_PEERS acts as MAX_PEERS.
module raft_leader_election_unit #(
  parameter int MAX_PEERS = rle_pkg::MAX_PEERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic [31:0]                     term,
  input  logic [7:0]                      sender_id,
  input  logic signed [31:0]              entry_index,
  input  logic [31:0]                     entry_term,
  input  logic [31:0]                     request_term,
  input  logic                            granted,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      kind,
  output logic [2:0]                      peer_slot,
  output logic [31:0]                     msg_term,
  output logic [7:0]                      msg_candidate,
  output logic signed [31:0]              msg_last_index,
  output logic [31:0]                     msg_last_term,
  output logic                            answer_grant,
  output logic [1:0]                      vote_state,
  output logic [30:0]                     next_index_out,
  output logic                            restart_timer,
  output logic                            last
);
  import rle_pkg::*;

  localparam int PW = $clog2(MAX_PEERS + 1);

  logic [7:0]    self_id;
  logic [3:0]    peer_count;
  logic [PW-1:0] np;
  logic          push_valid;
  logic          push_ready;
  rle_entry_t    push_data;
  logic          pop_valid;
  logic          pop_ready;
  rle_entry_t    pop_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id    <= '0;
      peer_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SELF_ID:    self_id    <= cfg_data;
        REG_PEER_COUNT: peer_count <= cfg_data[3:0];
        default:        ;
      endcase
    end
  end

  // Active peer count, capped at the table size
  assign np = (32'(peer_count) > 32'(MAX_PEERS)) ? PW'(MAX_PEERS) : PW'(peer_count);

  rle_front #(
    .MAX_PEERS (MAX_PEERS)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .term         (term),
    .sender_id    (sender_id),
    .entry_index  (entry_index),
    .entry_term   (entry_term),
    .request_term (request_term),
    .granted      (granted),
    .np           (np),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  rle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rle_back #(
    .MAX_PEERS (MAX_PEERS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .self_id        (self_id),
    .np             (np),
    .q_valid        (pop_valid),
    .q_pop          (pop_ready),
    .q_data         (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .peer_slot      (peer_slot),
    .msg_term       (msg_term),
    .msg_candidate  (msg_candidate),
    .msg_last_index (msg_last_index),
    .msg_last_term  (msg_last_term),
    .answer_grant   (answer_grant),
    .vote_state     (vote_state),
    .next_index_out (next_index_out),
    .restart_timer  (restart_timer),
    .last           (last)
  );

endmodule

`default_nettype wire
